// File: rtl/core/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the cosine curve smoother: divider request
// and response bundles and the fixed field widths.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// Fixed widths of the stream fields
	localparam int unsigned COORD_W = 16;
	localparam int unsigned SEGW_W  = 10;
	localparam int unsigned COS_W   = 17;   // Q1.15 plus room for +1.0

	// Shared divider: unsigned dividend over divisor
	localparam int unsigned DIVD_W  = 16;
	localparam int unsigned DIVS_W  = SEGW_W;

	// Segment width used after reset
	localparam logic [SEGW_W-1:0] SEGW_RESET = SEGW_W'(8);

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
		logic [DIVS_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: rtl/core/ccs_div.sv
// ----------------------------------------------------------------------------
// ccs_div
// Restoring divider shared by every quotient the smoother needs; one
// quotient bit per cycle, done is high for a single cycle once the last bit is in.
// ----------------------------------------------------------------------------
module ccs_div (
	input  logic             clk,
	input  logic             arst_n,
	input  ccs_pkg::div_req_t req,
	output ccs_pkg::div_rsp_t rsp
);
	import ccs_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIVD_W);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              fits;

	// Trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	// Control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/core/ccs_cos_rom.sv
// ----------------------------------------------------------------------------
// ccs_cos_rom
// Cosine table over [0, pi) in Q1.15, built at elaboration from a truncated
// Taylor series in Q28; registered read.
// ----------------------------------------------------------------------------
module ccs_cos_rom #(
	parameter int unsigned TABLE_SIZE = 256
) (
	input  logic                                 clk,
	input  logic [$clog2(TABLE_SIZE)-1:0]        addr,
	output logic signed [ccs_pkg::COS_W-1:0]     data
);
	import ccs_pkg::*;

	localparam longint unsigned PI_Q28  = 64'd843314857;
	localparam longint unsigned ONE_Q28 = 64'd268435456;

	// cos(pi*k/TABLE_SIZE), folded into [0, pi/2], series through x^14
	function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned k_in);
		int unsigned      k;
		logic             neg;
		longint unsigned  x;
		longint unsigned  x2;
		longint unsigned  mag;
		longint           sum;
		longint unsigned  rnd;
		k   = k_in;
		neg = 1'b0;
		if (2 * k > TABLE_SIZE) begin
			k   = TABLE_SIZE - k;
			neg = 1'b1;
		end
		x   = (PI_Q28 * longint'(k)) / TABLE_SIZE;
		x2  = (x * x) >> 28;
		mag = ONE_Q28;
		sum = longint'(ONE_Q28);
		mag = ((mag * x2) >> 28) / 2;   sum = sum - longint'(mag);
		mag = ((mag * x2) >> 28) / 12;  sum = sum + longint'(mag);
		mag = ((mag * x2) >> 28) / 30;  sum = sum - longint'(mag);
		mag = ((mag * x2) >> 28) / 56;  sum = sum + longint'(mag);
		mag = ((mag * x2) >> 28) / 90;  sum = sum - longint'(mag);
		mag = ((mag * x2) >> 28) / 132; sum = sum + longint'(mag);
		mag = ((mag * x2) >> 28) / 182; sum = sum - longint'(mag);
		if (sum < 0) begin
			sum = 0;
		end
		rnd = (longint'(sum) + 4096) >> 13;
		return neg ? -COS_W'(rnd) : COS_W'(rnd);
	endfunction

	logic signed [COS_W-1:0] rom [TABLE_SIZE];

	// Constant entries
	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
		assign rom[g] = cos_entry(g);
	end

	// Registered read
	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule

// File: rtl/core/cosine_curve_smoother.sv
// ----------------------------------------------------------------------------
// cosine_curve_smoother
// Cosine interpolation between successive key points: each span is cut into
// h segments and h points are produced along a half cosine.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                | payload
//  s_axis    | in  | tvalid / tready          | tdata {key_y, key_x}, tuser start_curve
//  m_axis    | out | tvalid / tready          | tdata {point_y, point_x}, tlast last_of_run
//  cfg       | in  | cfg_wr_en (no wait)      | cfg_wr_data segment pitch
//
// A key point that yields no points is taken without leaving idle; a span shorter
// than one segment skips the divider and goes through accept, table read,
// multiply and emit. Otherwise the shared divider runs three divisions
// (segment count, x step, table step), then each point goes through table
// read, multiply and emit, and emit waits while m_axis stalls. Reset clears
// the stored point, sets the segment width to 8 and clears m_axis_tvalid.
// The input is not ready while a span is being worked off.
// ----------------------------------------------------------------------------
module cosine_curve_smoother #(
	parameter int unsigned MAX_SEGMENTS = 64,
	parameter int unsigned TABLE_SIZE   = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,   // key_x, key_y
	input  logic                          s_axis_tuser,   // start_curve
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,   // point_x, point_y
	output logic                          m_axis_tlast,   // last_of_run
	input  logic                          cfg_wr_en,
	input  logic [ccs_pkg::SEGW_W-1:0]    cfg_wr_data
);
	import ccs_pkg::*;

	localparam int unsigned H_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
	localparam int unsigned DX_W  = COORD_W + 1;
	localparam int unsigned PROD_W = 2 * DX_W;
	localparam int unsigned S_W   = PROD_W + 2;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV_H = 7'b0000010,
		ST_DIV_X = 7'b0000100,
		ST_DIV_K = 7'b0001000,
		ST_TBL   = 7'b0010000,
		ST_MUL   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [SEGW_W-1:0]        segw_q;
	logic [SEGW_W-1:0]        segw_eff;
	logic signed [COORD_W-1:0] prev_x_q;
	logic signed [COORD_W-1:0] prev_y_q;
	logic                     have_prev_q;

	logic signed [COORD_W-1:0] key_x;
	logic signed [COORD_W-1:0] key_y;
	logic                     in_fire;
	logic signed [DX_W-1:0]   dx_new;

	logic signed [COORD_W-1:0] x0_q;
	logic signed [DX_W-1:0]   dx_q;
	logic signed [DX_W-1:0]   ysum_q;
	logic signed [DX_W-1:0]   ydif_q;
	logic [H_W-1:0]           h_q;
	logic [H_W-1:0]           j_q;
	logic [DIVD_W-1:0]        dqx_q;
	logic [H_W-1:0]           drx_q;
	logic [IDX_W-1:0]         dqk_q;
	logic [H_W-1:0]           drk_q;
	logic [COORD_W-1:0]       pxq_q;
	logic [H_W-1:0]           pxr_q;
	logic [IDX_W-1:0]         kq_q;
	logic [H_W-1:0]           kr_q;
	logic                     div_wait_q;

	logic [H_W:0]             pxr_sum;
	logic [H_W:0]             kr_sum;
	logic                     px_wrap;
	logic                     k_wrap;

	logic signed [COS_W-1:0]  cos_val;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [S_W-1:0]    s_sum;
	logic signed [S_W-17:0]   py_full;
	logic signed [COORD_W-1:0] py_sat;
	logic signed [COORD_W-1:0] px_val;
	logic                     last_pt;
	logic                     emit_fire;

	logic                     out_valid_q;
	logic [COORD_W-1:0]       out_x_q;
	logic [COORD_W-1:0]       out_y_q;
	logic                     out_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Input unpacking and acceptance
	assign key_x         = s_axis_tdata[COORD_W-1:0];
	assign key_y         = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign dx_new        = DX_W'(key_x) - DX_W'(prev_x_q);
	assign segw_eff      = (segw_q == '0) ? SEGW_W'(1) : segw_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segw_q <= SEGW_RESET;
		end else if (cfg_wr_en) begin
			segw_q <= cfg_wr_data;
		end
	end

	// Drive the shared divider for the three setup quotients
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = dx_q[DIVD_W-1:0];
		div_req.divisor  = DIVS_W'(h_q);
		unique case (state_q)
			ST_DIV_H: begin
				div_req.divisor = segw_eff;
			end
			ST_DIV_K: begin
				div_req.dividend = DIVD_W'(TABLE_SIZE);
			end
			default: begin
			end
		endcase
		if ((state_q == ST_DIV_H || state_q == ST_DIV_X || state_q == ST_DIV_K)
				&& !div_wait_q) begin
			div_req.start = 1'b1;
		end
	end

	ccs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ccs_cos_rom #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_cos_rom (
		.clk  (clk),
		.addr (kq_q),
		.data (cos_val)
	);

	// Incremental floor(j*dx/h) and j*TABLE_SIZE/h
	assign pxr_sum = {1'b0, pxr_q} + {1'b0, drx_q};
	assign kr_sum  = {1'b0, kr_q} + {1'b0, drk_q};
	assign px_wrap = pxr_sum >= {1'b0, h_q};
	assign k_wrap  = kr_sum >= {1'b0, h_q};

	// y = floor((ysum*2^15 + ydif*cos + 2^15) / 2^16), saturated
	assign s_sum   = (S_W'(ysum_q) <<< 15) + S_W'(prod_q) + S_W'(32768);
	assign py_full = s_sum[S_W-1:16];
	always_comb begin
		priority if (py_full > (S_W-16)'(32767)) begin
			py_sat = 16'sh7FFF;
		end else if (py_full < -(S_W-16)'(32768)) begin
			py_sat = -16'sh8000;
		end else begin
			py_sat = py_full[COORD_W-1:0];
		end
	end
	assign px_val    = x0_q + pxq_q;
	assign last_pt   = (j_q == h_q - H_W'(1));
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	// Sequencer and datapath control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			div_wait_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						prev_x_q    <= key_x;
						prev_y_q    <= key_y;
						have_prev_q <= 1'b1;
						if (!s_axis_tuser && have_prev_q) begin
							if (dx_new >= $signed(DX_W'(segw_eff))) begin
								state_q <= ST_DIV_H;
							end else begin
								state_q <= ST_TBL;
							end
						end
					end
				end
				ST_DIV_H, ST_DIV_X, ST_DIV_K: begin
					if (!div_wait_q) begin
						div_wait_q <= 1'b1;
					end else if (div_rsp.done) begin
						div_wait_q <= 1'b0;
						unique case (state_q)
							ST_DIV_H: state_q <= ST_DIV_X;
							ST_DIV_X: state_q <= ST_DIV_K;
							default:  state_q <= ST_TBL;
						endcase
					end
				end
				ST_TBL: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= last_pt ? ST_IDLE : ST_TBL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Span working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x0_q   <= prev_x_q;
			dx_q   <= dx_new;
			ysum_q <= DX_W'(prev_y_q) + DX_W'(key_y);
			ydif_q <= DX_W'(prev_y_q) - DX_W'(key_y);
			h_q    <= H_W'(1);
			j_q    <= '0;
			pxq_q  <= '0;
			pxr_q  <= '0;
			kq_q   <= '0;
			kr_q   <= '0;
			dqx_q  <= '0;
			drx_q  <= '0;
			dqk_q  <= '0;
			drk_q  <= '0;
		end
		if (div_wait_q && div_rsp.done) begin
			unique case (state_q)
				ST_DIV_H: begin
					if (div_rsp.quot > DIVD_W'(MAX_SEGMENTS)) begin
						h_q <= H_W'(MAX_SEGMENTS);
					end else begin
						h_q <= div_rsp.quot[H_W-1:0];
					end
				end
				ST_DIV_X: begin
					dqx_q <= div_rsp.quot;
					drx_q <= div_rsp.rem[H_W-1:0];
				end
				default: begin
					dqk_q <= div_rsp.quot[IDX_W-1:0];
					drk_q <= div_rsp.rem[H_W-1:0];
				end
			endcase
		end
		if (state_q == ST_MUL) begin
			prod_q <= ydif_q * cos_val;
		end
		// Advance to the next point
		if (emit_fire && !last_pt) begin
			j_q <= j_q + H_W'(1);
			if (px_wrap) begin
				pxq_q <= pxq_q + dqx_q + COORD_W'(1);
				pxr_q <= H_W'(pxr_sum - {1'b0, h_q});
			end else begin
				pxq_q <= pxq_q + dqx_q;
				pxr_q <= pxr_sum[H_W-1:0];
			end
			if (k_wrap) begin
				kq_q <= kq_q + dqk_q + IDX_W'(1);
				kr_q <= H_W'(kr_sum - {1'b0, h_q});
			end else begin
				kq_q <= kq_q + dqk_q;
				kr_q <= kr_sum[H_W-1:0];
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_x_q    <= px_val;
			out_y_q    <= py_sat;
			out_last_q <= last_pt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/ccs_checker.sv
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks on the smoother's stream behavior, bound to the top.
// ----------------------------------------------------------------------------
module ccs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// Hold a stalled result request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A curve start yields no points, so the input stays open
	a_start_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
		else $error("input closed after curve start");

	// Points of a span still pending: no new key point taken
	a_span_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready in the middle of a span");

	// Drop results once reset has been seen
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind cosine_curve_smoother ccs_checker u_ccs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
